>>> rtl/awm_pkg.sv
`timescale 1ns / 1ps

package awm_pkg;

  localparam int STAMP_W    = 32;
  localparam int DUR_W      = 24;
  localparam int SUM_W      = 30;
  localparam int CNT_OUT_W  = 7;
  localparam int DUTY_W     = 16;
  localparam int WIN_W      = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Dividend of the shared divider: the window sum times ten needs 34 bits.
  localparam int DIVIDEND_W = SUM_W + 4;
  localparam int DIVISOR_W  = WIN_W;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

  localparam logic [WIN_W-1:0]     WINDOW_RESET = 16'd20000;
  localparam logic [DUTY_W-1:0]    DUTY_MAX     = 16'hFFFF;
  localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX  = 7'h7F;

  // Register index, taken from paddr[2].
  localparam logic REG_WINDOW = 1'b0;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [DUR_W-1:0]   duration;
  } ring_entry_t;

endpackage

>>> rtl/awm_ring.sv
`timescale 1ns / 1ps

module awm_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  awm_pkg::ring_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output awm_pkg::ring_entry_t rdata
);

  awm_pkg::ring_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/awm_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle once the quotient is complete.
module awm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [awm_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [awm_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             done,
  output logic [awm_pkg::DIVIDEND_W-1:0]   quotient
);

  logic                               busy;
  logic [awm_pkg::STEP_W-1:0]         steps;
  logic [awm_pkg::DIVISOR_W-1:0]      rem;
  logic [awm_pkg::DIVISOR_W-1:0]      dsor;
  logic [awm_pkg::DIVISOR_W:0]        rem_shift;
  logic [awm_pkg::DIVISOR_W+1:0]      diff;

  assign rem_shift = {rem, quotient[awm_pkg::DIVIDEND_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == awm_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsor     <= divisor;
      rem      <= '0;
      steps    <= awm_pkg::STEP_W'(awm_pkg::DIVIDEND_W);
    end else if (busy) begin
      steps <= steps - awm_pkg::STEP_W'(1);
      if (!diff[awm_pkg::DIVISOR_W+1]) begin
        rem      <= diff[awm_pkg::DIVISOR_W-1:0];
        quotient <= {quotient[awm_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[awm_pkg::DIVISOR_W-1:0];
        quotient <= {quotient[awm_pkg::DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/airtime_window_meter.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// config    psel/penable/pwrite/pready  paddr, pwdata, prdata (window_ms at 0x0)
// item      item_valid/item_ready       timestamp_ms, duration_us
// result    result_valid/result_ready   last_duration_us, average_us, window_sum_us,
//                                       entries_in_window, duty_centipercent
//
// A transaction runs through accept, a walk back over the older ring entries (first priming
// the registered read, then reading the entries in turn), two divider passes (mean, duty;
// no duty pass with a zero window) and one output load. The first transaction after reset
// skips the walk. item_ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the sequencer holds before loading it until that
// register is free. Reset is synchronous.
module airtime_window_meter #(
  parameter int RING_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [awm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [awm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [awm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [awm_pkg::STAMP_W-1:0]       timestamp_ms,
  input  logic [awm_pkg::DUR_W-1:0]         duration_us,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [awm_pkg::DUR_W-1:0]         last_duration_us,
  output logic [awm_pkg::DUR_W-1:0]         average_us,
  output logic [awm_pkg::SUM_W-1:0]         window_sum_us,
  output logic [awm_pkg::CNT_OUT_W-1:0]     entries_in_window,
  output logic [awm_pkg::DUTY_W-1:0]        duty_centipercent
);

  localparam int AW = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
  localparam int CW = $clog2(RING_ENTRIES + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_AVG  = 5'b00100,
    ST_DUTY = 5'b01000,
    ST_SEND = 5'b10000
  } state_t;

  state_t                             state;
  logic [awm_pkg::WIN_W-1:0]          window;
  logic [AW-1:0]                      wp;
  logic [AW-1:0]                      rd_addr;
  logic [CW-1:0]                      live;
  logic [CW-1:0]                      live_inc;
  logic [CW-1:0]                      kept;
  logic [CW-1:0]                      kept_upd;
  logic [CW-1:0]                      remaining;
  logic [awm_pkg::SUM_W-1:0]          sum;
  logic [awm_pkg::SUM_W-1:0]          sum_upd;
  logic [awm_pkg::SUM_W:0]            sum_add;
  logic [awm_pkg::STAMP_W-1:0]        now_ms;
  logic [awm_pkg::DUR_W-1:0]          last_dur;
  logic [awm_pkg::DUR_W-1:0]          avg;
  logic [awm_pkg::DUTY_W-1:0]         duty;
  logic                               primed;
  logic [awm_pkg::STAMP_W-1:0]        age;
  logic                               age_ok;
  logic                               walk_end;
  logic                               accept;
  logic                               cfg_write;
  awm_pkg::ring_entry_t               wr_entry;
  awm_pkg::ring_entry_t               rd_entry;
  logic                               div_start;
  logic                               div_done;
  logic [awm_pkg::DIVIDEND_W-1:0]     div_dividend;
  logic [awm_pkg::DIVISOR_W-1:0]      div_divisor;
  logic [awm_pkg::DIVIDEND_W-1:0]     div_quotient;
  logic [awm_pkg::DIVIDEND_W-1:0]     sum_wide;

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    if (a == '0) begin
      return AW'(RING_ENTRIES - 1);
    end
    return a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    if (a == AW'(RING_ENTRIES - 1)) begin
      return '0;
    end
    return a + AW'(1);
  endfunction

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready
                      && (paddr[2] == awm_pkg::REG_WINDOW);
  assign prdata     = (paddr[2] == awm_pkg::REG_WINDOW)
                      ? awm_pkg::APB_DATA_W'(window) : '0;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  assign live_inc = (32'(live) < RING_ENTRIES) ? live + CW'(1) : live;

  // Wrapping age, so that the test holds across the timestamp roll-over.
  assign age      = now_ms - rd_entry.stamp;
  assign age_ok   = (age <= awm_pkg::STAMP_W'(window));
  assign sum_add  = {1'b0, sum} + (awm_pkg::SUM_W + 1)'(rd_entry.duration);
  assign kept_upd = age_ok ? kept + CW'(1) : kept;
  assign sum_upd  = !age_ok ? sum
                  : (sum_add[awm_pkg::SUM_W] ? '1 : sum_add[awm_pkg::SUM_W-1:0]);
  assign walk_end = primed && (!age_ok || remaining == CW'(1));
  assign sum_wide = awm_pkg::DIVIDEND_W'(sum);

  assign wr_entry.stamp    = timestamp_ms;
  assign wr_entry.duration = duration_us;

  awm_ring #(
    .DEPTH (RING_ENTRIES),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  awm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= awm_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      window <= pwdata[awm_pkg::WIN_W-1:0];
    end
  end

  // A division starts after the first transaction, at the end of the walk, and for the duty.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (accept && live_inc == CW'(1))
                   || (state == ST_WALK && walk_end)
                   || (state == ST_AVG && div_done && window != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wp           <= '0;
      live         <= '0;
      sum          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != ST_SEND) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            wp        <= ring_inc(wp);
            rd_addr   <= ring_dec(wp);
            now_ms    <= timestamp_ms;
            last_dur  <= duration_us;
            kept      <= CW'(1);
            sum       <= awm_pkg::SUM_W'(duration_us);
            remaining <= live_inc - CW'(1);
            primed    <= 1'b0;
            // The newest entry is always inside the window, so it is counted here.
            if (live_inc == CW'(1)) begin
              live         <= CW'(1);
              div_dividend <= awm_pkg::DIVIDEND_W'(duration_us);
              div_divisor  <= awm_pkg::DIVISOR_W'(1);
              state        <= ST_AVG;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // The ring read is registered: the first cycle only fetches.
          rd_addr <= ring_dec(rd_addr);
          if (!primed) begin
            primed <= 1'b1;
          end else begin
            kept      <= kept_upd;
            sum       <= sum_upd;
            remaining <= remaining - CW'(1);
            if (walk_end) begin
              live         <= kept_upd;
              div_dividend <= awm_pkg::DIVIDEND_W'(sum_upd);
              div_divisor  <= awm_pkg::DIVISOR_W'(kept_upd);
              state        <= ST_AVG;
            end
          end
        end
        ST_AVG: begin
          if (div_done) begin
            avg <= div_quotient[awm_pkg::DUR_W-1:0];
            if (window == '0) begin
              duty  <= (sum != '0) ? awm_pkg::DUTY_MAX : '0;
              state <= ST_SEND;
            end else begin
              div_dividend <= (sum_wide << 3) + (sum_wide << 1);
              div_divisor  <= window;
              state        <= ST_DUTY;
            end
          end
        end
        ST_DUTY: begin
          if (div_done) begin
            duty  <= (|div_quotient[awm_pkg::DIVIDEND_W-1:awm_pkg::DUTY_W])
                     ? awm_pkg::DUTY_MAX : div_quotient[awm_pkg::DUTY_W-1:0];
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEND && (!result_valid || result_ready)) begin
      last_duration_us  <= last_dur;
      average_us        <= avg;
      window_sum_us     <= sum;
      entries_in_window <= (32'(live) > 32'(awm_pkg::CNT_OUT_MAX))
                           ? awm_pkg::CNT_OUT_MAX : awm_pkg::CNT_OUT_W'(live);
      duty_centipercent <= duty;
    end
  end

endmodule

>>> dv/airtime_window_meter_tb.sv
`timescale 1ns / 1ps

module airtime_window_meter_tb;

  localparam int RING = 64;
  localparam int SLOT_W = $clog2(RING);
  localparam logic [awm_pkg::APB_ADDR_W-1:0] WINDOW_ADDR = {awm_pkg::REG_WINDOW, 2'b00};
  localparam logic [awm_pkg::APB_ADDR_W-1:0] SPARE_ADDR  = {~awm_pkg::REG_WINDOW, 2'b00};
  localparam logic [awm_pkg::DUR_W-1:0] DUR_FULL = '1;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << awm_pkg::SUM_W) - 64'd1;

  typedef struct packed {
    logic [awm_pkg::DUR_W-1:0]     last_us;
    logic [awm_pkg::DUR_W-1:0]     mean_us;
    logic [awm_pkg::SUM_W-1:0]     sum_us;
    logic [awm_pkg::CNT_OUT_W-1:0] entries;
    logic [awm_pkg::DUTY_W-1:0]    duty;
  } airtime_figures_t;

  localparam airtime_figures_t NO_FIGURES = '0;

  typedef enum logic [1:0] {ROW_READ, ROW_WRITE, ROW_ITEM, ROW_ITEM_FIXED} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [awm_pkg::APB_ADDR_W-1:0]   addr;
    logic [awm_pkg::APB_DATA_W-1:0]   data;
    logic [awm_pkg::STAMP_W-1:0]      stamp;
    logic [awm_pkg::DUR_W-1:0]        dur;
    airtime_figures_t                 want;
  } plan_row_t;

  typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} ready_style_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            psel, penable, pwrite, pready;
  logic [awm_pkg::APB_ADDR_W-1:0]  paddr;
  logic [awm_pkg::APB_DATA_W-1:0]  pwdata, prdata;
  logic                            item_valid, item_ready;
  logic [awm_pkg::STAMP_W-1:0]     timestamp_ms;
  logic [awm_pkg::DUR_W-1:0]       duration_us;
  logic                            result_valid, result_ready;
  logic [awm_pkg::DUR_W-1:0]       last_duration_us, average_us;
  logic [awm_pkg::SUM_W-1:0]       window_sum_us;
  logic [awm_pkg::CNT_OUT_W-1:0]   entries_in_window;
  logic [awm_pkg::DUTY_W-1:0]      duty_centipercent;

  // Shadow of the ring and its bookkeeping, advanced once per accepted transaction.
  logic [awm_pkg::STAMP_W-1:0]     trail_stamp [RING];
  logic [awm_pkg::DUR_W-1:0]       trail_dur [RING];
  logic [SLOT_W-1:0]               trail_head = '0;
  int                              trail_live = 0;
  logic [awm_pkg::WIN_W-1:0]       window_setting = awm_pkg::WINDOW_RESET;

  airtime_figures_t       pending_figures [$];
  plan_row_t              directed_plan [$];
  int                     mismatch_count = 0;
  int                     results_seen = 0;

  airtime_window_meter #(.RING_ENTRIES(RING)) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .timestamp_ms(timestamp_ms),
    .duration_us(duration_us),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .last_duration_us(last_duration_us),
    .average_us(average_us),
    .window_sum_us(window_sum_us),
    .entries_in_window(entries_in_window),
    .duty_centipercent(duty_centipercent)
  );

  always #6 clk = ~clk;

  function automatic airtime_figures_t predict_airtime(
      input logic [awm_pkg::STAMP_W-1:0] now,
      input logic [awm_pkg::DUR_W-1:0] dur);
    airtime_figures_t fig;
    logic [SLOT_W-1:0] slot;
    logic [awm_pkg::STAMP_W-1:0] age;
    logic [63:0] total, quot;
    int kept;
    bit walking;
    trail_stamp[trail_head] = now;
    trail_dur[trail_head] = dur;
    trail_head = trail_head + SLOT_W'(1);
    if (trail_live < RING) trail_live = trail_live + 1;
    // Walk back from the newest entry; the first one older than the window ends the walk.
    slot = trail_head - SLOT_W'(1);
    kept = 0;
    total = '0;
    walking = 1'b1;
    for (int i = 0; i < trail_live; i++) begin
      if (walking) begin
        age = now - trail_stamp[slot];
        if (age > awm_pkg::STAMP_W'(window_setting)) begin
          walking = 1'b0;
        end else begin
          kept++;
          total = total + 64'(trail_dur[slot]);
        end
        slot = slot - SLOT_W'(1);
      end
    end
    if (total > SUM_LIMIT) total = SUM_LIMIT;
    trail_live = kept;
    fig = '0;
    if (kept != 0) begin
      quot = total / 64'(kept);
      fig.last_us = dur;
      fig.mean_us = quot[awm_pkg::DUR_W-1:0];
      fig.sum_us = total[awm_pkg::SUM_W-1:0];
      fig.entries = (kept > int'(awm_pkg::CNT_OUT_MAX)) ? awm_pkg::CNT_OUT_MAX
                                                         : awm_pkg::CNT_OUT_W'(kept);
      if (window_setting == '0) begin
        fig.duty = (total != 0) ? awm_pkg::DUTY_MAX : '0;
      end else begin
        quot = (total * 64'd10) / 64'(window_setting);
        fig.duty = (quot > 64'(awm_pkg::DUTY_MAX)) ? awm_pkg::DUTY_MAX
                                                    : quot[awm_pkg::DUTY_W-1:0];
      end
    end
    return fig;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", field, want, got);
      mismatch_count = mismatch_count + 1;
    end
  endtask

  task automatic apb_access(input logic is_write,
                            input logic [awm_pkg::APB_ADDR_W-1:0] addr,
                            input logic [awm_pkg::APB_DATA_W-1:0] wdata,
                            output logic [awm_pkg::APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (is_write && addr[2] == awm_pkg::REG_WINDOW) begin
      window_setting = wdata[awm_pkg::WIN_W-1:0];
    end
  endtask

  // The window may only change once every outstanding transaction has produced its result.
  task automatic retune_window(input logic [awm_pkg::APB_ADDR_W-1:0] addr,
                               input logic [awm_pkg::APB_DATA_W-1:0] value);
    logic [awm_pkg::APB_DATA_W-1:0] ignored;
    item_valid <= 1'b0;
    while (pending_figures.size() != 0) @(posedge clk);
    apb_access(1'b1, addr, value, ignored);
  endtask

  task automatic send_transmission(input logic [awm_pkg::STAMP_W-1:0] stamp,
                                   input logic [awm_pkg::DUR_W-1:0] dur, input bit pinned,
                                   input airtime_figures_t pinned_figures);
    airtime_figures_t predicted;
    item_valid <= 1'b1;
    timestamp_ms <= stamp;
    duration_us <= dur;
    do @(posedge clk); while (!item_ready);
    predicted = predict_airtime(stamp, dur);
    pending_figures.push_back(pinned ? pinned_figures : predicted);
  endtask

  always @(posedge clk) begin : result_check
    airtime_figures_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen = results_seen + 1;
      if (pending_figures.size() == 0) begin
        $error("result transaction arrived with nothing outstanding");
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_figures.pop_front();
        check_field("last_duration_us", 32'(want.last_us), 32'(last_duration_us));
        check_field("average_us", 32'(want.mean_us), 32'(average_us));
        check_field("window_sum_us", 32'(want.sum_us), 32'(window_sum_us));
        check_field("entries_in_window", 32'(want.entries), 32'(entries_in_window));
        check_field("duty_centipercent", 32'(want.duty), 32'(duty_centipercent));
      end
    end
  end

  initial begin : receiver
    ready_style_t style;
    int unsigned stretch, tick;
    bit held_off;
    result_ready = 1'b0;
    held_off = 1'b0;
    tick = 0;
    forever begin
      if (!held_off && results_seen >= 300 && item_valid) begin
        // Hold results back long enough that the block fills and refuses new transactions.
        @(posedge clk);
        result_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        held_off = 1'b1;
      end
      style = ready_style_t'($urandom_range(0, 3));
      stretch = $urandom_range(10, 250);
      repeat (stretch) begin
        @(posedge clk);
        tick++;
        case (style)
          RX_STEADY: result_ready <= 1'b1;
          RX_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
          default:   result_ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    logic [awm_pkg::APB_DATA_W-1:0] readback;
    logic [awm_pkg::STAMP_W-1:0] cursor, delta;
    logic [awm_pkg::DUR_W-1:0] dur;
    logic [awm_pkg::WIN_W-1:0] span;
    int unsigned burst_left, gap, pick;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_valid = 1'b0;
    timestamp_ms = '0;
    duration_us = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_plan.push_back({ROW_READ, WINDOW_ADDR, 32'd20000, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM_FIXED, WINDOW_ADDR, 32'd0, 32'd0, 24'd0,
                             {24'd0, 24'd0, 30'd0, 7'd1, 16'd0}});
    directed_plan.push_back({ROW_ITEM_FIXED, WINDOW_ADDR, 32'd0, 32'd100, DUR_FULL,
                             {DUR_FULL, 24'd8388607, 30'd16777215, 7'd2, 16'd8388}});
    // The entry stamped 100 is exactly one window old here and must survive.
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'd20100, 24'd1000, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'd20101, 24'd5, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'hFFFF_FFF0, 24'd123456,
                             NO_FIGURES});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'h0000_0010, 24'd777,
                             NO_FIGURES});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'h0000_000F, 24'd1, NO_FIGURES});
    directed_plan.push_back({ROW_WRITE, WINDOW_ADDR, 32'd0, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_READ, WINDOW_ADDR, 32'd0, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM_FIXED, WINDOW_ADDR, 32'd0, 32'd5000, 24'd0,
                             {24'd0, 24'd0, 30'd0, 7'd1, 16'd0}});
    directed_plan.push_back({ROW_ITEM_FIXED, WINDOW_ADDR, 32'd0, 32'd5000, 24'd7,
                             {24'd7, 24'd3, 30'd7, 7'd2, awm_pkg::DUTY_MAX}});
    directed_plan.push_back({ROW_ITEM_FIXED, WINDOW_ADDR, 32'd0, 32'd5001, 24'd1,
                             {24'd1, 24'd1, 30'd1, 7'd1, awm_pkg::DUTY_MAX}});
    // A write to an unmapped register must leave the zero window in place.
    directed_plan.push_back({ROW_WRITE, SPARE_ADDR, 32'd1, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_READ, WINDOW_ADDR, 32'd0, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM_FIXED, WINDOW_ADDR, 32'd0, 32'd5002, 24'd2,
                             {24'd2, 24'd2, 30'd2, 7'd1, awm_pkg::DUTY_MAX}});
    directed_plan.push_back({ROW_WRITE, WINDOW_ADDR, 32'd1, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM_FIXED, WINDOW_ADDR, 32'd0, 32'd9000, DUR_FULL,
                             {DUR_FULL, DUR_FULL, 30'(DUR_FULL), 7'd1,
                              awm_pkg::DUTY_MAX}});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'd9001, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'd9002, 24'd3, NO_FIGURES});
    directed_plan.push_back({ROW_WRITE, WINDOW_ADDR, 32'd65535, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_READ, WINDOW_ADDR, 32'd65535, 32'd0, 24'd0, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'd70000, DUR_FULL, NO_FIGURES});
    directed_plan.push_back({ROW_ITEM, WINDOW_ADDR, 32'd0, 32'd70000, 24'd0, NO_FIGURES});

    foreach (directed_plan[r]) begin
      row = directed_plan[r];
      case (row.kind)
        ROW_READ: begin
          apb_access(1'b0, row.addr, '0, readback);
          check_field("prdata", row.data, readback);
        end
        ROW_WRITE: retune_window(row.addr, row.data);
        default: begin
          send_transmission(row.stamp, row.dur, row.kind == ROW_ITEM_FIXED, row.want);
          item_valid <= 1'b0;
          @(posedge clk);
        end
      endcase
    end

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0, 6: span = '1;
        1: span = 16'd1;
        2: span = '0;
        4: span = awm_pkg::WINDOW_RESET;
        5: span = 16'($urandom_range(2, 300));
        default: span = 16'($urandom_range(1, 65534));
      endcase
      retune_window(WINDOW_ADDR, awm_pkg::APB_DATA_W'(span));
      cursor = (phase % 2 != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
      burst_left = 0;
      for (int n = 0; n < 136; n++) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 12);
          if (n != 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 200)
                                              : $urandom_range(1, 8);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        // Mostly small steps so the ring fills; sometimes a step of exactly one window,
        // one just past it, a repeat of the same time, a far jump or a step backwards.
        pick = $urandom_range(0, 99);
        if (pick < 60) delta = $urandom_range(0, span / 64 + 1);
        else if (pick < 75) delta = $urandom_range(0, span / 8 + 1);
        else if (pick < 83) delta = 32'(span);
        else if (pick < 88) delta = 32'(span) + 32'd1;
        else if (pick < 93) delta = '0;
        else if (pick < 97) delta = $urandom();
        else delta = -$urandom_range(1, 1000);
        cursor = cursor + delta;
        pick = $urandom_range(0, 9);
        if (pick == 0) dur = DUR_FULL;
        else if (pick == 1) dur = '0;
        else if (pick < 6) dur = 24'($urandom());
        else dur = 24'($urandom_range(0, 5000));
        send_transmission(cursor, dur, 1'b0, NO_FIGURES);
      end
    end

    item_valid <= 1'b0;
    while (pending_figures.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("airtime_window_meter_tb: clean");
    end else begin
      $display("airtime_window_meter_tb: errors");
    end
    $finish;
  end

  initial begin : deadline
    #15ms;
    $display("airtime_window_meter_tb: errors");
    $finish;
  end

endmodule
